[hw/rtl/mcp_pkg.sv]
// mcp_pkg: types, codes and constants shared by the protocol message parser
// no dependencies; imported by every module of the block but mcp_fifo
`timescale 1ns / 1ps

package mcp_pkg;

  localparam int MCP_GROUPS    = 16;
  localparam int MCP_CMD_DEPTH = 2;
  localparam int MCP_OUT_DEPTH = 2;

  localparam int GRP_W  = 4;
  localparam int MK_W   = 3;
  localparam int POS_W  = 10;
  localparam int DATA_W = 7;
  localparam int EVT_W  = 2;
  localparam int Q_W    = 8;
  localparam int IDX_W  = 3;

  // record bytes kept in storage; the last one always arrives with its event
  localparam int REC_STORED   = 4;
  localparam int REC_LAST_IDX = 4;

  localparam int POS_AUTH       = 13;
  localparam int POS_COUNT      = 14;
  localparam int POS_REC        = 15;
  localparam int POS_SET_FIRST  = 14;
  localparam int POS_SET_LAST   = 18;
  localparam int POS_TEST_FIRST = 14;
  localparam int POS_TEST_LAST  = 61;

  // floor(x / 5) = (x * 205) >> 10 for every x below 1024
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;

  typedef enum logic [MK_W-1:0] {
    MK_NEG     = 3'd0,
    MK_REPLY   = 3'd1,
    MK_SET     = 3'd2,
    MK_TEST    = 3'd3,
    MK_TRESP   = 3'd4,
    MK_CONFIRM = 3'd5
  } msg_kind_t;

  typedef enum logic [EVT_W-1:0] {
    EVT_OFFER   = 2'd0,
    EVT_SET     = 2'd1,
    EVT_TEST    = 2'd2,
    EVT_CONFIRM = 2'd3
  } evt_kind_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [GRP_W-1:0]  grp;
    logic [MK_W-1:0]   mk;
    logic [DATA_W-1:0] data;
    logic              wr_auth;
    logic              wr_count;
    logic              rec_wr;
    logic              rec_lim;
    logic [Q_W-1:0]    rec_q;
    logic [IDX_W-1:0]  rec_idx;
    logic              test_set;
    logic              test_clr;
    logic              evt_en;
    evt_kind_t         evt;
  } cmd_t;

  typedef struct packed {
    evt_kind_t         evt;
    logic [GRP_W-1:0]  grp;
    logic [MK_W-1:0]   mk;
    logic [DATA_W-1:0] auth;
    logic [DATA_W-1:0] b0;
    logic [DATA_W-1:0] b1;
    logic [DATA_W-1:0] b2;
    logic [DATA_W-1:0] b3;
    logic [DATA_W-1:0] b4;
    logic              passed;
  } res_t;

endpackage

[hw/rtl/mcp_fifo.sv]
// mcp_fifo: small register queue with push/full and pop/empty sides
// depends on nothing but its parameters
`timescale 1ns / 1ps

module mcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/mcp_front.sv]
// mcp_front: decodes message kind and byte position into a command word
// depends on mcp_pkg
`timescale 1ns / 1ps

module mcp_front import mcp_pkg::*; #(
  parameter int GROUPS = MCP_GROUPS
) (
  input  logic [GRP_W-1:0]  grp,
  input  logic [MK_W-1:0]   msg_kind,
  input  logic [POS_W-1:0]  byte_pos,
  input  logic [DATA_W-1:0] data_byte,
  output cmd_t              cmd,
  output logic              cmd_valid
);

  logic [POS_W-1:0]        rel;
  logic [POS_W-1:0]        tofs;
  logic [POS_W+Q_W-1:0]    prod;
  logic [Q_W-1:0]          q;
  logic [Q_W+2:0]          q5;
  logic [POS_W-1:0]        rem;
  logic                    in_range;

  // record slot within a negotiation list: (pos - 15) split into quotient and mod 5
  assign rel  = byte_pos - POS_W'(POS_REC);
  assign tofs = byte_pos - POS_W'(POS_TEST_FIRST);
  assign prod = (POS_W+Q_W)'(rel) * (POS_W+Q_W)'(DIV5_MUL);
  assign q    = prod[DIV5_SHIFT +: Q_W];
  assign q5   = ((Q_W+3)'(q) << 2) + (Q_W+3)'(q);
  assign rem  = rel - POS_W'(q5);

  assign in_range = (int'(grp) < GROUPS);

  always_comb begin
    cmd          = '0;
    cmd.grp      = grp;
    cmd.mk       = msg_kind;
    cmd.data     = data_byte;
    cmd.rec_q    = q;
    cmd.evt      = EVT_OFFER;
    unique case (msg_kind) inside
      MK_NEG, MK_REPLY: begin
        cmd.wr_auth  = (byte_pos == POS_W'(POS_AUTH));
        cmd.wr_count = (byte_pos == POS_W'(POS_COUNT));
        cmd.rec_wr   = (byte_pos >= POS_W'(POS_REC));
        cmd.rec_lim  = 1'b1;
        cmd.rec_idx  = rem[IDX_W-1:0];
        cmd.evt_en   = cmd.rec_wr && (rem[IDX_W-1:0] == IDX_W'(REC_LAST_IDX));
        cmd.evt      = EVT_OFFER;
      end
      MK_SET: begin
        cmd.wr_auth = (byte_pos == POS_W'(POS_AUTH));
        cmd.rec_wr  = (byte_pos >= POS_W'(POS_SET_FIRST)) &&
                      (byte_pos <= POS_W'(POS_SET_LAST));
        cmd.rec_idx = tofs[IDX_W-1:0];
        cmd.evt_en  = (byte_pos == POS_W'(POS_SET_LAST));
        cmd.evt     = EVT_SET;
      end
      MK_TEST, MK_TRESP: begin
        cmd.wr_auth  = (byte_pos == POS_W'(POS_AUTH));
        cmd.test_set = (byte_pos == POS_W'(POS_AUTH));
        cmd.test_clr = (byte_pos >= POS_W'(POS_TEST_FIRST)) &&
                       (byte_pos <= POS_W'(POS_TEST_LAST)) &&
                       (data_byte != tofs[DATA_W-1:0]);
        cmd.evt_en   = (byte_pos == POS_W'(POS_TEST_LAST));
        cmd.evt      = EVT_TEST;
      end
      MK_CONFIRM: begin
        cmd.wr_auth = (byte_pos == POS_W'(POS_AUTH));
        cmd.evt_en  = (byte_pos == POS_W'(POS_AUTH));
        cmd.evt     = EVT_CONFIRM;
      end
      default: begin
        cmd.evt = EVT_OFFER;
      end
    endcase
  end

  // bytes that touch nothing, or whose group is out of range, are dropped here
  assign cmd_valid = in_range & (cmd.wr_auth | cmd.wr_count | cmd.rec_wr |
                                 cmd.test_set | cmd.test_clr | cmd.evt_en);

endmodule

[hw/rtl/mcp_back.sv]
// mcp_back: per-group state and result assembly, one command word a cycle while the result queue is not full
// depends on mcp_pkg
`timescale 1ns / 1ps

module mcp_back import mcp_pkg::*; #(
  parameter int GROUPS = MCP_GROUPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic out_full,
  output logic res_valid,
  output res_t res
);

  localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [DATA_W-1:0] auth_r  [GROUPS];
  logic [DATA_W-1:0] count_r [GROUPS];
  logic [DATA_W-1:0] rec_r   [GROUPS][REC_STORED];
  logic              test_ok_r [GROUPS];

  logic [GIW-1:0] gi;
  logic           fire;
  logic           rec_ok;
  logic           emit;
  logic           with_rec;

  assign gi   = cmd.grp[GIW-1:0];
  assign fire = cmd_valid & ~out_full;
  assign cmd_pop = fire;

  // negotiation records only count while inside the announced list
  assign rec_ok = cmd.rec_wr & (~cmd.rec_lim | (cmd.rec_q < {1'b0, count_r[gi]}));
  assign emit   = cmd.evt_en & (~cmd.rec_lim | rec_ok);
  assign res_valid = fire & emit;

  assign with_rec = (cmd.evt == EVT_OFFER) || (cmd.evt == EVT_SET);

  always_comb begin
    res        = '0;
    res.evt    = cmd.evt;
    res.grp    = cmd.grp;
    res.mk     = cmd.mk;
    res.auth   = cmd.wr_auth ? cmd.data : auth_r[gi];
    if (with_rec) begin
      res.b0 = rec_r[gi][0];
      res.b1 = rec_r[gi][1];
      res.b2 = rec_r[gi][2];
      res.b3 = rec_r[gi][3];
      res.b4 = cmd.data;
    end
    res.passed = (cmd.evt == EVT_TEST) & test_ok_r[gi] & ~cmd.test_clr;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (cmd.wr_auth) begin
        auth_r[gi] <= cmd.data;
      end
      if (rec_ok && (cmd.rec_idx != IDX_W'(REC_LAST_IDX))) begin
        rec_r[gi][cmd.rec_idx[1:0]] <= cmd.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GROUPS; i++) begin
        count_r[i]   <= '0;
        test_ok_r[i] <= 1'b0;
      end
    end else if (fire) begin
      if (cmd.wr_count) begin
        count_r[gi] <= cmd.data;
      end
      if (cmd.test_set) begin
        test_ok_r[gi] <= 1'b1;
      end else if (cmd.test_clr) begin
        test_ok_r[gi] <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/midi_ci_protocol_message_parser.sv]
// MIDI-CI protocol message parser: takes one 7-bit sysex byte per cycle with its
// group, message kind and position, and queues protocol-offered, set-protocol,
// test-result and confirm events. A byte is accepted every cycle while full is
// low; the result of a byte shows on the output after it has passed both queues
// (decode into the command queue, then per-group state update into the result
// queue). Throughput is one byte per cycle, set by the single read-modify-write
// of per-group state in the back end; it holds as long as results are popped.
// Authority levels and record bytes read before being written return garbage.
// Depends on mcp_pkg, mcp_front, mcp_fifo and mcp_back.
`timescale 1ns / 1ps

module midi_ci_protocol_message_parser import mcp_pkg::*; #(
  parameter int GROUPS    = MCP_GROUPS,
  parameter int CMD_DEPTH = MCP_CMD_DEPTH,
  parameter int OUT_DEPTH = MCP_OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              push,
  output logic              full,
  input  logic [GRP_W-1:0]  in_group,
  input  logic [MK_W-1:0]   in_msg_kind,
  input  logic [POS_W-1:0]  in_byte_pos,
  input  logic [DATA_W-1:0] in_data_byte,

  output logic              empty,
  input  logic              pop,
  output logic [EVT_W-1:0]  out_event_kind,
  output logic [GRP_W-1:0]  out_event_group,
  output logic [MK_W-1:0]   out_event_msg_kind,
  output logic [DATA_W-1:0] out_authority,
  output logic [DATA_W-1:0] out_proto_byte0,
  output logic [DATA_W-1:0] out_proto_byte1,
  output logic [DATA_W-1:0] out_proto_byte2,
  output logic [DATA_W-1:0] out_proto_byte3,
  output logic [DATA_W-1:0] out_proto_byte4,
  output logic              out_test_passed
);

  cmd_t cmd_in, cmd_q;
  logic cmd_in_valid;
  logic [$bits(cmd_t)-1:0] cmd_rd;
  logic cmd_empty, cmd_pop;

  res_t res_in, res_q;
  logic res_valid, res_full;
  logic [$bits(res_t)-1:0] res_rd;

  mcp_front #(
    .GROUPS (GROUPS)
  ) u_front (
    .grp       (in_group),
    .msg_kind  (in_msg_kind),
    .byte_pos  (in_byte_pos),
    .data_byte (in_data_byte),
    .cmd       (cmd_in),
    .cmd_valid (cmd_in_valid)
  );

  mcp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push & cmd_in_valid),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rd),
    .empty (cmd_empty)
  );

  assign cmd_q = cmd_t'(cmd_rd);

  mcp_back #(
    .GROUPS (GROUPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .res_valid (res_valid),
    .res       (res_in)
  );

  mcp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rd),
    .empty (empty)
  );

  assign res_q = res_t'(res_rd);

  assign out_event_kind     = res_q.evt;
  assign out_event_group    = res_q.grp;
  assign out_event_msg_kind = res_q.mk;
  assign out_authority      = res_q.auth;
  assign out_proto_byte0    = res_q.b0;
  assign out_proto_byte1    = res_q.b1;
  assign out_proto_byte2    = res_q.b2;
  assign out_proto_byte3    = res_q.b3;
  assign out_proto_byte4    = res_q.b4;
  assign out_test_passed    = res_q.passed;

  // test and confirm words carry no record bytes
  a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_event_kind == EVT_TEST || out_event_kind == EVT_CONFIRM) |->
      out_proto_byte0 == '0 && out_proto_byte1 == '0 && out_proto_byte2 == '0 &&
      out_proto_byte3 == '0 && out_proto_byte4 == '0)
    else $error("record bytes set on a test or confirm word");

  a_offer_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_event_kind == EVT_OFFER |->
      out_event_msg_kind == MK_NEG || out_event_msg_kind == MK_REPLY)
    else $error("protocol offered from a non-negotiation message");

  a_set_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_event_kind == EVT_SET |-> out_event_msg_kind == MK_SET)
    else $error("set protocol word from another message kind");

  a_pass_only_test: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_test_passed |-> out_event_kind == EVT_TEST)
    else $error("pass flag on a word that is not a test result");

endmodule

[tb/tb.sv]
// tb: self-checking bench for midi_ci_protocol_message_parser, a word per push
// and per pop; expected events come from a behavioral copy of the per-group state
// depends on mcp_pkg and midi_ci_protocol_message_parser
`timescale 1ns / 1ps

module tb;
  import mcp_pkg::*;

  localparam int REC_LEN      = 5;
  localparam int ITEMS_TARGET = 1650;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              push         = 1'b0;
  logic              full;
  logic [GRP_W-1:0]  in_group     = '0;
  logic [MK_W-1:0]   in_msg_kind  = '0;
  logic [POS_W-1:0]  in_byte_pos  = '0;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [EVT_W-1:0]  out_event_kind;
  logic [GRP_W-1:0]  out_event_group;
  logic [MK_W-1:0]   out_event_msg_kind;
  logic [DATA_W-1:0] out_authority;
  logic [DATA_W-1:0] out_proto_byte0;
  logic [DATA_W-1:0] out_proto_byte1;
  logic [DATA_W-1:0] out_proto_byte2;
  logic [DATA_W-1:0] out_proto_byte3;
  logic [DATA_W-1:0] out_proto_byte4;
  logic              out_test_passed;

  // shadow of the per-group parser state
  logic [DATA_W-1:0] auth_lvl  [MCP_GROUPS];
  logic [DATA_W-1:0] proto_cnt [MCP_GROUPS];
  logic [DATA_W-1:0] rec_buf   [MCP_GROUPS][REC_LEN];
  logic              test_pass [MCP_GROUPS];
  bit                auth_seen [MCP_GROUPS];
  bit                rec_seen  [MCP_GROUPS][REC_LEN];

  res_t pending_events[$];
  int   err_count   = 0;
  int   work_done   = 0;
  int   cycle_count = 0;
  int   stall_left  = 0;
  bit   src_gaps    = 1'b1;
  bit   sink_stalls = 1'b1;

  midi_ci_protocol_message_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_group           (in_group),
    .in_msg_kind        (in_msg_kind),
    .in_byte_pos        (in_byte_pos),
    .in_data_byte       (in_data_byte),
    .empty              (empty),
    .pop                (pop),
    .out_event_kind     (out_event_kind),
    .out_event_group    (out_event_group),
    .out_event_msg_kind (out_event_msg_kind),
    .out_authority      (out_authority),
    .out_proto_byte0    (out_proto_byte0),
    .out_proto_byte1    (out_proto_byte1),
    .out_proto_byte2    (out_proto_byte2),
    .out_proto_byte3    (out_proto_byte3),
    .out_proto_byte4    (out_proto_byte4),
    .out_test_passed    (out_test_passed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int g = 0; g < MCP_GROUPS; g++) begin
      proto_cnt[g] = '0;
      test_pass[g] = 1'b0;
      auth_lvl[g]  = '0;
      auth_seen[g] = 1'b0;
      for (int i = 0; i < REC_LEN; i++) begin
        rec_buf[g][i]  = '0;
        rec_seen[g][i] = 1'b0;
      end
    end
  end

  // update the shadow state with one accepted word, queue the event it raises
  task automatic parse_byte(input logic [GRP_W-1:0] g, input logic [MK_W-1:0] mk,
                            input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] d);
    res_t ev;
    int   p;
    int   idx;
    bit   fire;
    bit   with_rec;
    ev       = '0;
    p        = pos;
    fire     = 1'b0;
    with_rec = 1'b0;
    ev.grp   = g;
    ev.mk    = mk;
    case (mk)
      MK_NEG, MK_REPLY: begin
        if (p == POS_AUTH) begin
          auth_lvl[g]  = d;
          auth_seen[g] = 1'b1;
        end
        if (p == POS_COUNT) proto_cnt[g] = d;
        if (p >= POS_REC && p < POS_REC + REC_LEN * int'(proto_cnt[g])) begin
          idx             = (p - POS_REC) % REC_LEN;
          rec_buf[g][idx]  = d;
          rec_seen[g][idx] = 1'b1;
          if (idx == REC_LAST_IDX) begin
            ev.evt   = EVT_OFFER;
            fire     = 1'b1;
            with_rec = 1'b1;
          end
        end
      end
      MK_SET: begin
        if (p == POS_AUTH) begin
          auth_lvl[g]  = d;
          auth_seen[g] = 1'b1;
        end
        if (p >= POS_SET_FIRST && p <= POS_SET_LAST) begin
          rec_buf[g][p - POS_SET_FIRST]  = d;
          rec_seen[g][p - POS_SET_FIRST] = 1'b1;
        end
        if (p == POS_SET_LAST) begin
          ev.evt   = EVT_SET;
          fire     = 1'b1;
          with_rec = 1'b1;
        end
      end
      MK_TEST, MK_TRESP: begin
        if (p == POS_AUTH) begin
          auth_lvl[g]  = d;
          auth_seen[g] = 1'b1;
          test_pass[g] = 1'b1;
        end
        if (p >= POS_TEST_FIRST && p <= POS_TEST_LAST && int'(d) != p - POS_TEST_FIRST)
          test_pass[g] = 1'b0;
        if (p == POS_TEST_LAST) begin
          ev.evt    = EVT_TEST;
          ev.passed = test_pass[g];
          fire      = 1'b1;
        end
      end
      MK_CONFIRM: begin
        if (p == POS_AUTH) begin
          auth_lvl[g]  = d;
          auth_seen[g] = 1'b1;
          ev.evt       = EVT_CONFIRM;
          fire         = 1'b1;
        end
      end
      default: ;
    endcase
    if (fire) begin
      ev.auth = auth_lvl[g];
      if (with_rec) begin
        ev.b0 = rec_buf[g][0];
        ev.b1 = rec_buf[g][1];
        ev.b2 = rec_buf[g][2];
        ev.b3 = rec_buf[g][3];
        ev.b4 = rec_buf[g][4];
      end
      pending_events.push_back(ev);
    end
  endtask

  // an event would report authority or record bytes never written since reset
  function automatic bit reads_unwritten(input logic [GRP_W-1:0] g,
                                         input logic [MK_W-1:0] mk,
                                         input logic [POS_W-1:0] pos);
    int p;
    bit all_known;
    p         = pos;
    all_known = auth_seen[g] && rec_seen[g][0] && rec_seen[g][1] &&
                rec_seen[g][2] && rec_seen[g][3];
    case (mk)
      MK_NEG, MK_REPLY:
        return p >= POS_REC && p < POS_REC + REC_LEN * int'(proto_cnt[g]) &&
               (p - POS_REC) % REC_LEN == REC_LAST_IDX && !all_known;
      MK_SET:            return p == POS_SET_LAST && !all_known;
      MK_TEST, MK_TRESP: return p == POS_TEST_LAST && !auth_seen[g];
      default:           return 1'b0;
    endcase
  endfunction

  function automatic bit counts_as_work(input logic [GRP_W-1:0] g,
                                        input logic [MK_W-1:0] mk,
                                        input logic [POS_W-1:0] pos);
    int p;
    p = pos;
    return mk <= MK_CONFIRM && p >= POS_AUTH &&
           (p <= POS_TEST_LAST ||
            (mk <= MK_REPLY && p < POS_REC + REC_LEN * int'(proto_cnt[g])));
  endfunction

  function automatic int gap_len();
    int r;
    if (!src_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // send one word; words whose event would read unwritten storage are dropped
  task automatic push_byte(input logic [GRP_W-1:0] g, input logic [MK_W-1:0] mk,
                           input int pos, input int d);
    int gap;
    if (reads_unwritten(g, mk, pos[POS_W-1:0])) return;
    gap = gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_group     <= g;
    in_msg_kind  <= mk;
    in_byte_pos  <= pos[POS_W-1:0];
    in_data_byte <= d[DATA_W-1:0];
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (counts_as_work(g, mk, pos[POS_W-1:0])) work_done++;
    parse_byte(g, mk, pos[POS_W-1:0], d[DATA_W-1:0]);
  endtask

  task automatic send_record(input logic [GRP_W-1:0] g, input logic [MK_W-1:0] mk,
                             input int q, input int skip_pct);
    for (int i = 0; i < REC_LEN; i++) begin
      if ($urandom_range(1, 100) > skip_pct)
        push_byte(g, mk, POS_REC + REC_LEN * q + i, $urandom_range(0, 127));
    end
  endtask

  task automatic send_offer_list(input logic [GRP_W-1:0] g, input logic [MK_W-1:0] mk,
                                 input bit broken);
    int cnt;
    int skip_pct;
    skip_pct = broken ? 15 : 0;
    cnt      = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 127);
    if (!broken || $urandom_range(0, 1)) push_byte(g, mk, POS_AUTH, $urandom_range(0, 127));
    if (!broken || $urandom_range(0, 1)) push_byte(g, mk, POS_COUNT, cnt);
    if (cnt <= 8) begin
      for (int q = 0; q < cnt; q++) send_record(g, mk, q, skip_pct);
      if ($urandom_range(0, 2) == 0) send_record(g, mk, cnt, skip_pct);
    end else begin
      // long lists: a few records picked anywhere, up to one past the end
      repeat ($urandom_range(1, 4)) send_record(g, mk, $urandom_range(0, cnt), skip_pct);
    end
  endtask

  task automatic send_set(input logic [GRP_W-1:0] g, input bit broken);
    for (int p = POS_AUTH; p <= POS_SET_LAST; p++) begin
      if (!broken || $urandom_range(0, 4) != 0) push_byte(g, MK_SET, p, $urandom_range(0, 127));
    end
  endtask

  task automatic send_pattern(input logic [GRP_W-1:0] g, input logic [MK_W-1:0] mk,
                              input int flavor);
    int bad_pos;
    int d;
    bad_pos = $urandom_range(POS_TEST_FIRST, POS_TEST_LAST);
    for (int p = POS_AUTH; p <= POS_TEST_LAST; p++) begin
      d = (p == POS_AUTH) ? $urandom_range(0, 127) : p - POS_TEST_FIRST;
      case (flavor)
        1: if (p == bad_pos) d = (d + $urandom_range(1, 127)) % 128;
        2: if (p == POS_AUTH) continue;
        3: if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 127);
        default: ;
      endcase
      push_byte(g, mk, p, d);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      push_byte($urandom_range(0, 15), $urandom_range(0, 7),
                $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(10, 65),
                $urandom_range(0, 127));
    end
  endtask

  task automatic test_edges();
    push_byte(0, MK_CONFIRM, POS_AUTH, 0);
    push_byte(15, MK_CONFIRM, POS_AUTH, 127);
    push_byte(15, MK_SET, 13, 127);
    push_byte(15, MK_SET, 14, 0);
    push_byte(15, MK_SET, 15, 127);
    push_byte(15, MK_SET, 16, 85);
    push_byte(15, MK_SET, 17, 42);
    push_byte(15, MK_SET, 18, 127);
    push_byte(0, MK_NEG, 13, 1);
    push_byte(0, MK_NEG, 14, 1);
    push_byte(0, MK_NEG, 15, 127);
    push_byte(0, MK_NEG, 16, 0);
    push_byte(0, MK_NEG, 17, 64);
    push_byte(0, MK_NEG, 18, 1);
    push_byte(0, MK_NEG, 19, 126);
    push_byte(0, MK_NEG, 20, 99);
    // test result with no opening byte: flag still at its reset value
    push_byte(0, MK_TRESP, POS_TEST_LAST, 47);
    push_byte(15, MK_TEST, POS_AUTH, 127);
    push_byte(15, MK_TEST, POS_TEST_LAST, 47);
    push_byte(3, 3'd6, POS_AUTH, 127);
    push_byte(3, 3'd7, 1023, 127);
    push_byte(0, MK_NEG, 1023, 127);
    push_byte(0, MK_SET, 0, 0);
    push_byte(15, MK_REPLY, POS_COUNT, 0);
    push_byte(15, MK_REPLY, 19, 5);
  endtask

  // largest protocol count: records at both ends and one past the last
  task automatic test_long_offer_list();
    push_byte(7, MK_REPLY, POS_AUTH, $urandom_range(0, 127));
    push_byte(7, MK_REPLY, POS_COUNT, 127);
    send_record(7, MK_REPLY, 0, 0);
    send_record(7, MK_REPLY, 63, 0);
    send_record(7, MK_REPLY, 126, 0);
    send_record(7, MK_REPLY, 127, 0);
    push_byte(7, MK_REPLY, 1023, 0);
  endtask

  task automatic test_pattern_checks();
    send_pattern(9, MK_TEST, 0);
    send_pattern(9, MK_TRESP, 1);
    send_pattern(9, MK_TEST, 2);
  endtask

  task automatic test_random_traffic();
    int               r;
    logic [GRP_W-1:0] g;
    while (work_done < ITEMS_TARGET) begin
      src_gaps    = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      g           = $urandom_range(0, 15);
      r           = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2))
          push_byte(g, $urandom_range(0, 5), $urandom_range(0, 12), $urandom_range(0, 127));
      end
      if (r < 30)      send_offer_list(g, $urandom_range(0, 1) ? MK_NEG : MK_REPLY, 1'b0);
      else if (r < 48) send_set(g, 1'b0);
      else if (r < 60) send_pattern(g, $urandom_range(0, 1) ? MK_TEST : MK_TRESP,
                                    $urandom_range(0, 3));
      else if (r < 75) push_byte(g, MK_CONFIRM, POS_AUTH, $urandom_range(0, 127));
      else if (r < 85) send_noise();
      else if (r < 93) send_offer_list(g, $urandom_range(0, 1) ? MK_NEG : MK_REPLY, 1'b1);
      else             send_set(g, 1'b1);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result side: check each popped word, then pick the next pop with random stalls
  always @(posedge clk) begin : result_sink
    res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_events.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected event: kind %0d group %0d msg_kind %0d",
                   out_event_kind, out_event_group, out_event_msg_kind);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.evt, out_event_kind);
        check_field("event_group", want.grp, out_event_group);
        check_field("event_msg_kind", want.mk, out_event_msg_kind);
        check_field("authority", want.auth, out_authority);
        check_field("proto_byte0", want.b0, out_proto_byte0);
        check_field("proto_byte1", want.b1, out_proto_byte1);
        check_field("proto_byte2", want.b2, out_proto_byte2);
        check_field("proto_byte3", want.b3, out_proto_byte3);
        check_field("proto_byte4", want.b4, out_proto_byte4);
        check_field("test_passed", want.passed, out_test_passed);
      end
    end
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (!sink_stalls || $urandom_range(0, 99) < 70) begin
      pop <= 1'b1;
    end else begin
      pop        <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_long_offer_list();
    test_pattern_checks();
    test_random_traffic();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // every expected word is gone, so anything still queued is extra
    if (!empty) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("unexpected event left in the result queue");
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[midi_ci_protocol_message_parser.f]
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_fifo.sv
hw/rtl/mcp_front.sv
hw/rtl/mcp_back.sv
hw/rtl/midi_ci_protocol_message_parser.sv
tb/tb.sv
